### hw/rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and codes for the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int OFFSET_BITS = 32;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_ADVISE = 2'd2;

  localparam logic [1:0] KIND_FREE    = 2'd0;
  localparam logic [1:0] KIND_NORMAL  = 2'd1;
  localparam logic [1:0] KIND_DISCARD = 2'd2;

  localparam logic [1:0] ADV_NORMAL  = 2'd0;
  localparam logic [1:0] ADV_DISCARD = 2'd1;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND    = 3'd1;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd2;
  localparam logic [2:0] ST_NO_MEMORY    = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL   = 3'd4;
  localparam logic [2:0] ST_IGNORED      = 3'd5;
  localparam logic [2:0] ST_BAD          = 3'd6;

  localparam logic REG_HEAP_SIZE = 1'b0;
  localparam logic REG_ALIGNMENT = 1'b1;

  localparam int HEAP_RESET  = 268435456;
  localparam int ALIGN_RESET = 256;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_SCAN,
    S_SHIFT,
    S_SPLIT,
    S_REST,
    S_DONE
  } state_t;

endpackage

### hw/rtl/first_fit_segment_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_core
// First-fit heap segment allocator over an address-ordered segment table.
// ----------------------------------------------------------------------------
// One request at a time; the table sits in one memory with a registered read.
// A bad request (zero-byte alloc or operation three) goes straight to the
// result. Free and advise scan one entry per cycle and stop at the entry
// that holds the offset, or at the fill count when none does.
// Alloc first rounds the size with a bit-serial remainder step, then scans:
// an exact fit, a full table or no fit ends the scan there;
// a split shifts the tail up one entry per cycle and then writes the used
// entry and the free rest. The result waits in an output register, so a
// stalled result holds back only the hand-off of the next one, not its
// acceptance. Entries at or above the fill count are never used, so a
// heap_size write rebuilds the table with no clearing pass.
module first_fit_segment_allocator_core
  import ffsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] request_size,
  input  logic [31:0] target_offset,
  input  logic [1:0]  advice_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] result_offset
);

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int OB = OFFSET_BITS;
  localparam int EW = 3 * OB + 2;
  localparam logic [CW-1:0] CMAX = CW'(MAX_SEGMENTS);

  // entry layout: {offset, size, user, kind}
  function automatic logic [EW-1:0] pack(logic [OB-1:0] o, logic [OB-1:0] s,
                                         logic [OB-1:0] u, logic [1:0] k);
    return {o, s, u, k};
  endfunction

  logic [OB-1:0] heap_size;
  logic [16:0]   alignment;
  logic [CW-1:0] count;
  state_t        state, state_next;
  logic          accept;

  logic [1:0]    op;
  logic [OB-1:0] req, off;
  logic [1:0]    akind;
  logic [OB:0]   asize;    // rounded alloc size, spare bit keeps the carry
  logic [OB-1:0] sreq;     // request bits still to enter the remainder
  logic [16:0]   rem;
  logic [4:0]    bcnt;

  logic [CW-1:0] cidx;     // entry whose data is in rdata
  logic [CW-1:0] hit;      // free entry being split
  logic [OB-1:0] h_off, h_size;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic [OB-1:0] e_off, e_size, e_user;
  logic [1:0]    e_kind;
  logic [OB:0]   e_end;
  logic          fits, exact, holds_off, in_range;

  logic [16:0]   aeff;
  logic [17:0]   rtry;
  logic [16:0]   rem_next;
  logic [OB:0]   pad;

  logic [2:0]    p_st;     // result waiting for the output register
  logic [OB-1:0] p_off;
  logic [2:0]    st_r;
  logic [OB-1:0] res_r;
  logic          o_valid;
  logic [2:0]    st_n;
  logic [OB-1:0] res_n;
  logic          fin;
  logic          hand_off;

  ffsa_table #(.DEPTH(MAX_SEGMENTS), .WIDTH(EW)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign {e_off, e_size, e_user, e_kind} = rdata;
  assign e_end = {1'b0, e_off} + {1'b0, e_size};

  // round up to a multiple of the alignment; zero acts as one
  assign aeff     = (alignment == 17'd0) ? 17'd1 : alignment;
  assign rtry     = {rem, sreq[OB-1]};
  assign rem_next = (rtry >= {1'b0, aeff}) ? 17'(rtry - {1'b0, aeff}) : rtry[16:0];
  assign pad      = (rem_next == 17'd0) ? '0 : (OB+1)'(aeff - rem_next);

  assign fits      = (e_kind == KIND_FREE) && ({1'b0, e_size} >= asize);
  assign exact     = ({1'b0, e_size} == asize);
  assign holds_off = (off < heap_size) && (off >= e_off) && ({1'b0, off} < e_end);
  assign in_range  = (cidx < count);

  assign in_stall      = (state != S_IDLE);
  assign accept        = in_valid && !in_stall;
  assign hand_off      = (state == S_DONE) && (!o_valid || !out_stall);
  assign out_valid     = o_valid;
  assign status        = st_r;
  assign result_offset = res_r;

  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    fin   = 1'b0;
    st_n  = ST_OK;
    res_n = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (operation == OP_ALLOC && request_size != 32'd0) begin
            state_next = S_ROUND;
          end else if (operation inside {OP_FREE, OP_ADVISE}) begin
            state_next = S_SCAN;
          end else begin
            fin  = 1'b1;
            st_n = ST_BAD;
          end
        end
        if (fin) state_next = S_DONE;
      end
      S_ROUND: begin
        if (bcnt == 5'(OB - 1)) state_next = S_SCAN;
      end
      S_SCAN: begin
        raddr = AW'(cidx + CW'(1));
        if (!in_range) begin
          fin  = 1'b1;
          st_n = (op == OP_ALLOC) ? ST_NO_MEMORY : ST_NOT_FOUND;
        end else if (op == OP_ALLOC) begin
          if (fits) begin
            if (exact) begin
              we = 1'b1; waddr = AW'(cidx);
              wdata = pack(e_off, e_size, req, KIND_NORMAL);
              fin = 1'b1; res_n = e_off;
            end else if (count >= CMAX) begin
              fin = 1'b1; st_n = ST_TABLE_FULL;
            end else if (cidx == count - CW'(1)) begin
              state_next = S_SPLIT;
            end else begin
              // start the tail shift from the last entry
              raddr = AW'(count - CW'(1));
              state_next = S_SHIFT;
            end
          end
        end else if (holds_off) begin
          if (e_kind == KIND_FREE) begin
            fin = 1'b1; st_n = ST_ALREADY_FREE;
          end else if (op == OP_FREE) begin
            we = 1'b1; waddr = AW'(cidx);
            wdata = pack(e_off, e_size, '0, KIND_FREE);
            fin = 1'b1;
          end else if (akind == ADV_NORMAL) begin
            we = 1'b1; waddr = AW'(cidx);
            wdata = pack(e_off, e_size, e_user, KIND_NORMAL);
            fin = 1'b1;
          end else if (akind == ADV_DISCARD && off == e_off && req >= e_user) begin
            we = 1'b1; waddr = AW'(cidx);
            wdata = pack(e_off, e_size, e_user, KIND_DISCARD);
            fin = 1'b1;
          end else begin
            fin = 1'b1; st_n = ST_IGNORED;
          end
        end
        if (fin) state_next = S_DONE;
      end
      S_SHIFT: begin
        // move entry cidx up by one, read the one below
        raddr = AW'(cidx - CW'(1));
        we    = 1'b1;
        waddr = AW'(cidx + CW'(1));
        wdata = rdata;
        if (cidx == hit + CW'(1)) state_next = S_SPLIT;
      end
      S_SPLIT: begin
        we    = 1'b1;
        waddr = AW'(hit);
        wdata = pack(h_off, asize[OB-1:0], req, KIND_NORMAL);
        state_next = S_REST;
      end
      S_REST: begin
        we    = 1'b1;
        waddr = AW'(hit + CW'(1));
        wdata = pack(h_off + asize[OB-1:0], h_size - asize[OB-1:0], '0, KIND_FREE);
        fin   = 1'b1;
        res_n = h_off;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!o_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // rebuild the first entry on reset and on a heap_size write
    if (rst || (cfg_we && cfg_index == REG_HEAP_SIZE)) begin
      we    = 1'b1;
      waddr = '0;
      wdata = rst ? pack('0, OB'(HEAP_RESET), '0, KIND_FREE)
                  : pack('0, cfg_data, '0, KIND_FREE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_size <= OB'(HEAP_RESET);
      alignment <= 17'(ALIGN_RESET);
      count     <= CW'(1);
      o_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HEAP_SIZE) begin
          heap_size <= cfg_data;
          count     <= (cfg_data != 32'd0) ? CW'(1) : '0;
        end else begin
          alignment <= cfg_data[16:0];
        end
      end
      if (state == S_REST) count <= count + CW'(1);
      if (hand_off) begin
        o_valid <= 1'b1;
      end else if (o_valid && !out_stall) begin
        o_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (fin) begin
      p_st  <= st_n;
      p_off <= res_n;
    end
    if (hand_off) begin
      st_r  <= p_st;
      res_r <= p_off;
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          op    <= operation;
          req   <= request_size;
          off   <= target_offset;
          akind <= advice_kind;
          sreq  <= request_size;
          rem   <= '0;
          bcnt  <= '0;
          cidx  <= '0;
        end
      end
      S_ROUND: begin
        rem  <= rem_next;
        sreq <= sreq << 1;
        bcnt <= bcnt + 5'd1;
        if (bcnt == 5'(OB - 1)) asize <= {1'b0, req} + pad;
      end
      S_SCAN: begin
        cidx <= cidx + CW'(1);
        if (state_next == S_SHIFT) cidx <= count - CW'(1);
        if (state_next == S_SHIFT || state_next == S_SPLIT) begin
          hit    <= cidx;
          h_off  <= e_off;
          h_size <= e_size;
        end
      end
      S_SHIFT: begin
        cidx <= cidx - CW'(1);
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) o_valid && out_stall |=> o_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
                   o_valid && out_stall |=> $stable(st_r) && $stable(res_r))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (rst) count <= CMAX)
    else $error("segment count overflow");
  assert property (@(posedge clk) disable iff (rst) state == S_SPLIT |=> state == S_REST)
    else $error("split did not complete");

endmodule

### hw/rtl/ffsa_table.sv
// ----------------------------------------------------------------------------
// ffsa_table
// Segment table memory: one synchronous write port, one synchronous read port.
// ----------------------------------------------------------------------------
module ffsa_table #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 98
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
